// ===== hdl/ppcs_pkg.sv =====
// Shared types, field widths, register codes and defaults for the plane partition sweep unit.
`default_nettype none

package ppcs_pkg;

  // Default sizing of the height stores.
  localparam int DEF_MAX_ROWS    = 16;
  localparam int DEF_MAX_COLS    = 16;
  localparam int DEF_HEIGHT_BITS = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PART  = 2'd2;

  localparam int ROW_COUNT_W = 5;
  localparam int COL_COUNT_W = 5;
  localparam int MAX_PART_W  = 8;

  localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 5'd4;
  localparam logic [COL_COUNT_W-1:0] COL_COUNT_RESET = 5'd5;
  localparam logic [MAX_PART_W-1:0]  MAX_PART_RESET  = 8'd9;

  // Command and result word fields.
  localparam logic ACT_RESTART = 1'b0;
  localparam logic ACT_UPDATE  = 1'b1;

  localparam int CELL_W   = 4;
  localparam int HEIGHT_W = 8;
  localparam int VOLUME_W = 16;

  // Control for one height step: coin and which neighbours sit beyond the box edge.
  typedef struct packed {
    logic coin;
    logic vert_edge;
    logic horz_edge;
  } step_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/ppcs_if.sv =====
// Valid/ready channel interfaces for the command and result words.
`default_nettype none

interface ppcs_cmd_if;
  logic valid;
  logic ready;
  logic action;
  logic coin;

  modport source (output valid, output action, output coin, input ready);
  modport sink (input valid, input action, input coin, output ready);
endinterface

interface ppcs_res_if;
  logic                          valid;
  logic                          ready;
  logic [ppcs_pkg::CELL_W-1:0]   cell_row;
  logic [ppcs_pkg::CELL_W-1:0]   cell_col;
  logic [ppcs_pkg::HEIGHT_W-1:0] lower_height;
  logic [ppcs_pkg::HEIGHT_W-1:0] upper_height;
  logic [ppcs_pkg::VOLUME_W-1:0] gap_volume;
  logic                          sweep_done;
  logic                          coalesced;

  modport source (output valid, output cell_row, output cell_col, output lower_height,
                  output upper_height, output gap_volume, output sweep_done,
                  output coalesced, input ready);
  modport sink (input valid, input cell_row, input cell_col, input lower_height,
                input upper_height, input gap_volume, input sweep_done,
                input coalesced, output ready);
endinterface

`default_nettype wire

// ===== hdl/plane_partition_coupled_sweep_unit.sv =====
// Top level of the coupled plane partition sweep unit.
// Two height grids, lower and upper, live in two synchronous memories, each with two read
// ports and one write port. Per command word, the accepting cycle reads the current cell
// and its vertical neighbour, the horizontal state reads the horizontal neighbour on the
// second port, and the calc state computes both grids, writes the cell back on an update
// and loads the result register. A result that is not taken holds the unit in the calc
// state, but the next command is accepted while a result waits. A restart or a register
// write clears the grids at once with no clearing pass: a first-sweep flag makes unwritten
// cells read as their reset heights, since a sweep visits the cells in row-major order.
`default_nettype none

module plane_partition_coupled_sweep_unit #(
  parameter int MAX_ROWS    = ppcs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = ppcs_pkg::DEF_MAX_COLS,
  parameter int HEIGHT_BITS = ppcs_pkg::DEF_HEIGHT_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  ppcs_cmd_if.sink                            cmd,
  ppcs_res_if.source                          res,
  input  wire logic                           wr_en,
  input  wire logic [ppcs_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [ppcs_pkg::CFG_DATA_W-1:0] wr_data
);
  import ppcs_pkg::*;

  localparam int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW       = RW + CW;
  localparam int DEPTH    = 2 ** AW;
  localparam int RCW      = $clog2(MAX_ROWS + 1);
  localparam int CCW      = $clog2(MAX_COLS + 1);
  localparam int HMAX     = (2 ** HEIGHT_BITS) - 1;
  localparam int VOL_BITS = RCW + CCW + HEIGHT_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HORZ,
    ST_CALC
  } state_t;

  // Saturating register loads.
  function automatic logic [RCW-1:0] sat_rows(input logic [ROW_COUNT_W-1:0] v);
    logic [RCW-1:0] r;
    if (v == '0) r = RCW'(1);
    else if (int'(v) > MAX_ROWS) r = RCW'(MAX_ROWS);
    else r = RCW'(v);
    return r;
  endfunction

  function automatic logic [CCW-1:0] sat_cols(input logic [COL_COUNT_W-1:0] v);
    logic [CCW-1:0] r;
    if (v == '0) r = CCW'(1);
    else if (int'(v) > MAX_COLS) r = CCW'(MAX_COLS);
    else r = CCW'(v);
    return r;
  endfunction

  function automatic logic [HEIGHT_BITS-1:0] sat_top(input logic [MAX_PART_W-1:0] v);
    logic [HEIGHT_BITS-1:0] r;
    if (v == '0) r = HEIGHT_BITS'(1);
    else if (int'(v) > HMAX) r = HEIGHT_BITS'(HMAX);
    else r = HEIGHT_BITS'(v);
    return r;
  endfunction

  state_t                 state;
  logic                   action_q;
  logic                   coin_q;
  logic [RW-1:0]          scan_row;
  logic [CW-1:0]          scan_col;
  logic                   filled;
  logic                   fresh;
  logic [VOL_BITS-1:0]    volume_reg;

  logic [RCW-1:0]         rows_eff;
  logic [CCW-1:0]         cols_eff;
  logic [HEIGHT_BITS-1:0] top_eff;
  logic [RCW+CCW-1:0]     area;
  logic [VOL_BITS-1:0]    full_vol;

  logic [HEIGHT_BITS-1:0] lo_mem [DEPTH];
  logic [HEIGHT_BITS-1:0] hi_mem [DEPTH];
  logic [HEIGHT_BITS-1:0] lo_rd_a;
  logic [HEIGHT_BITS-1:0] lo_rd_b;
  logic [HEIGHT_BITS-1:0] hi_rd_a;
  logic [HEIGHT_BITS-1:0] hi_rd_b;
  logic [HEIGHT_BITS-1:0] lo_vert_q;
  logic [HEIGHT_BITS-1:0] hi_vert_q;

  logic                   cmd_fire;
  logic                   res_free;
  logic                   calc_fire;
  logic                   cfg_hit;
  logic                   rd_a_en;
  logic                   rd_b_en;
  logic                   mem_we;
  logic [AW-1:0]          addr_cur;
  logic [AW-1:0]          addr_b;
  logic                   row_last;
  logic                   col_last;
  logic                   nbr_live;
  step_ctl_t              ctl;
  logic [HEIGHT_BITS-1:0] lo_cur;
  logic [HEIGHT_BITS-1:0] hi_cur;
  logic [HEIGHT_BITS-1:0] lo_vert;
  logic [HEIGHT_BITS-1:0] hi_vert;
  logic [HEIGHT_BITS-1:0] lo_horz;
  logic [HEIGHT_BITS-1:0] hi_horz;
  logic [HEIGHT_BITS-1:0] lo_new;
  logic [HEIGHT_BITS-1:0] hi_new;
  logic                   lo_chg;
  logic                   hi_chg;
  logic [VOL_BITS-1:0]    vol_base;
  logic [VOL_BITS-1:0]    vol_next;

  assign cmd.ready = (state == ST_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign res_free  = !res.valid || res.ready;
  assign calc_fire = (state == ST_CALC) && res_free;
  assign cfg_hit   = wr_en && (wr_index == REG_ROW_COUNT || wr_index == REG_COL_COUNT ||
                               wr_index == REG_MAX_PART);

  // Configuration registers hold the saturated values.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_eff <= sat_rows(ROW_COUNT_RESET);
      cols_eff <= sat_cols(COL_COUNT_RESET);
      top_eff  <= sat_top(MAX_PART_RESET);
    end else if (wr_en) begin
      case (wr_index)
        REG_ROW_COUNT: rows_eff <= sat_rows(wr_data[ROW_COUNT_W-1:0]);
        REG_COL_COUNT: cols_eff <= sat_cols(wr_data[COL_COUNT_W-1:0]);
        REG_MAX_PART:  top_eff  <= sat_top(wr_data[MAX_PART_W-1:0]);
        default: ;
      endcase
    end
  end

  // Full box volume in two registered multiplications, area then volume; settled before any
  // command accepted after a register write reaches its final cycle.
  always_ff @(posedge clk) begin
    area     <= (RCW+CCW)'(rows_eff) * (RCW+CCW)'(cols_eff);
    full_vol <= VOL_BITS'(area) * VOL_BITS'(top_eff);
  end

  // Scan position and edge tests.
  assign row_last = ({1'b0, scan_row} + (RW+1)'(1)) >= (RW+1)'(rows_eff);
  assign col_last = ({1'b0, scan_col} + (CW+1)'(1)) >= (CW+1)'(cols_eff);

  assign addr_cur = {scan_row, scan_col};

  always_comb begin
    if (state == ST_IDLE) begin
      addr_b = cmd.coin ? {scan_row - RW'(1), scan_col} : {scan_row + RW'(1), scan_col};
    end else begin
      addr_b = coin_q ? {scan_row, scan_col - CW'(1)} : {scan_row, scan_col + CW'(1)};
    end
  end

  assign rd_a_en = cmd_fire;
  assign rd_b_en = cmd_fire || (state == ST_HORZ);
  assign mem_we  = calc_fire && (action_q == ACT_UPDATE);

  always_ff @(posedge clk) begin
    if (mem_we) lo_mem[addr_cur] <= lo_new;
    if (rd_a_en) lo_rd_a <= lo_mem[addr_cur];
    if (rd_b_en) lo_rd_b <= lo_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (mem_we) hi_mem[addr_cur] <= hi_new;
    if (rd_a_en) hi_rd_a <= hi_mem[addr_cur];
    if (rd_b_en) hi_rd_b <= hi_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (state == ST_HORZ) begin
      lo_vert_q <= lo_rd_b;
      hi_vert_q <= hi_rd_b;
    end
  end

  // During the first sweep after a restart, the current cell and the cells below and to the
  // right have not been written yet and take their reset heights. Cells above and to the left
  // have always been written before they are read.
  assign nbr_live = coin_q || filled;
  assign lo_cur   = filled ? lo_rd_a : '0;
  assign hi_cur   = filled ? hi_rd_a : top_eff;
  assign lo_vert  = nbr_live ? lo_vert_q : '0;
  assign hi_vert  = nbr_live ? hi_vert_q : top_eff;
  assign lo_horz  = nbr_live ? lo_rd_b : '0;
  assign hi_horz  = nbr_live ? hi_rd_b : top_eff;

  assign ctl.coin      = coin_q;
  assign ctl.vert_edge = coin_q ? (scan_row == '0) : row_last;
  assign ctl.horz_edge = coin_q ? (scan_col == '0) : col_last;

  ppcs_height_step #(
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_lo_step (
    .cur         (lo_cur),
    .vert        (lo_vert),
    .horz        (lo_horz),
    .top         (top_eff),
    .ctl         (ctl),
    .next_height (lo_new),
    .changed     (lo_chg)
  );

  ppcs_height_step #(
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_hi_step (
    .cur         (hi_cur),
    .vert        (hi_vert),
    .horz        (hi_horz),
    .top         (top_eff),
    .ctl         (ctl),
    .next_height (hi_new),
    .changed     (hi_chg)
  );

  // Right after a restart the running volume is the full box volume.
  assign vol_base = fresh ? full_vol : volume_reg;
  assign vol_next = vol_base + VOL_BITS'(coin_q ? hi_chg : lo_chg)
                             - VOL_BITS'(coin_q ? lo_chg : hi_chg);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res.valid <= 1'b0;
      scan_row  <= '0;
      scan_col  <= '0;
      filled    <= 1'b0;
      fresh     <= 1'b1;
    end else begin
      if (res.valid && res.ready && !calc_fire) begin
        res.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            action_q <= cmd.action;
            coin_q   <= cmd.coin;
            state    <= ST_HORZ;
          end
        end
        ST_HORZ: begin
          state <= ST_CALC;
        end
        ST_CALC: begin
          if (res_free) begin
            res.valid <= 1'b1;
            state     <= ST_IDLE;
            if (action_q == ACT_UPDATE) begin
              res.cell_row     <= CELL_W'(scan_row);
              res.cell_col     <= CELL_W'(scan_col);
              res.lower_height <= HEIGHT_W'(lo_new);
              res.upper_height <= HEIGHT_W'(hi_new);
              res.gap_volume   <= VOLUME_W'(vol_next);
              res.sweep_done   <= row_last && col_last;
              res.coalesced    <= (vol_next == '0);
              volume_reg       <= vol_next;
              fresh            <= 1'b0;
              if (col_last) begin
                scan_col <= '0;
                if (row_last) begin
                  scan_row <= '0;
                  filled   <= 1'b1;
                end else begin
                  scan_row <= scan_row + RW'(1);
                end
              end else begin
                scan_col <= scan_col + CW'(1);
              end
            end else begin
              res.cell_row     <= '0;
              res.cell_col     <= '0;
              res.lower_height <= '0;
              res.upper_height <= HEIGHT_W'(top_eff);
              res.gap_volume   <= VOLUME_W'(full_vol);
              res.sweep_done   <= 1'b0;
              res.coalesced    <= (full_vol == '0);
              scan_row         <= '0;
              scan_col         <= '0;
              filled           <= 1'b0;
              fresh            <= 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // A register write restarts both grids.
      if (cfg_hit) begin
        scan_row <= '0;
        scan_col <= '0;
        filled   <= 1'b0;
        fresh    <= 1'b1;
      end
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> !cmd.ready)
    else $error("command accepted while another is in flight");

  a_coupling_order: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> lo_new <= hi_new)
    else $error("lower grid rose above upper grid");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> !filled && fresh && scan_row == '0 && scan_col == '0)
    else $error("register write did not restart the grids");

  a_sweep_fill: assert property (@(posedge clk) disable iff (rst)
    mem_we && row_last && col_last && !cfg_hit |=> filled && scan_row == '0 && scan_col == '0)
    else $error("end of sweep did not wrap the scan and mark the grids written");

endmodule

`default_nettype wire

// ===== hdl/ppcs_height_step.sv =====
// One coin step on one height grid: decides whether the cell gains or loses a cube.
`default_nettype none

module ppcs_height_step #(
  parameter int HEIGHT_BITS = ppcs_pkg::DEF_HEIGHT_BITS
) (
  input  wire logic [HEIGHT_BITS-1:0] cur,
  input  wire logic [HEIGHT_BITS-1:0] vert,
  input  wire logic [HEIGHT_BITS-1:0] horz,
  input  wire logic [HEIGHT_BITS-1:0] top,
  input  wire ppcs_pkg::step_ctl_t    ctl,
  output logic      [HEIGHT_BITS-1:0] next_height,
  output logic                        changed
);
  import ppcs_pkg::*;

  logic [HEIGHT_BITS-1:0] up_vert;
  logic [HEIGHT_BITS-1:0] up_horz;
  logic [HEIGHT_BITS-1:0] dn_vert;
  logic [HEIGHT_BITS-1:0] dn_horz;
  logic                   can_add;
  logic                   can_remove;

  // Beyond the top or left edge a neighbour counts as the maximal part,
  // beyond the bottom or right edge as zero.
  assign up_vert = ctl.vert_edge ? top : vert;
  assign up_horz = ctl.horz_edge ? top : horz;
  assign dn_vert = ctl.vert_edge ? '0 : vert;
  assign dn_horz = ctl.horz_edge ? '0 : horz;

  assign can_add    = (up_vert > cur) && (up_horz > cur);
  assign can_remove = (cur > dn_vert) && (cur > dn_horz);

  always_comb begin
    if (ctl.coin) begin
      changed     = can_add;
      next_height = can_add ? cur + HEIGHT_BITS'(1) : cur;
    end else begin
      changed     = can_remove;
      next_height = can_remove ? cur - HEIGHT_BITS'(1) : cur;
    end
  end

endmodule

`default_nettype wire
